// ----- hdl/tctok_pkg.sv -----
package tctok_pkg;

  localparam int POS_W       = 16;
  localparam int MAX_KW_LEN  = 8;
  localparam int MAX_TOK     = 3;
  localparam int CNT_W       = $clog2(MAX_TOK + 1);
  localparam int TIDX_W      = $clog2(MAX_TOK);
  localparam int QDEPTH      = 2;
  localparam int QPTR_W      = $clog2(QDEPTH);
  localparam int QCNT_W      = $clog2(QDEPTH + 1);
  localparam int NUM_KW      = 33;

  localparam logic [5:0] ST_START = 6'd0;

  localparam logic [3:0] KIND_IDENT   = 4'd0;
  localparam logic [3:0] KIND_KEYWORD = 4'd1;
  localparam logic [3:0] KIND_NUMBER  = 4'd2;
  localparam logic [3:0] KIND_PUNCT   = 4'd3;
  localparam logic [3:0] KIND_STRING  = 4'd4;
  localparam logic [3:0] KIND_OPER    = 4'd5;
  localparam logic [3:0] KIND_ESCAPE  = 4'd6;
  localparam logic [3:0] KIND_CHAR    = 4'd7;
  localparam logic [3:0] KIND_PREPROC = 4'd8;
  localparam logic [3:0] KIND_COMMENT = 4'd9;
  localparam logic [3:0] KIND_INVALID = 4'd10;

  localparam logic [12:0] KW_SUMS [NUM_KW] = '{
    13'd411, 13'd433, 13'd987, 13'd1005, 13'd1015, 13'd1672, 13'd1676, 13'd1694,
    13'd1707, 13'd1712, 13'd1779, 13'd1793, 13'd1805, 13'd2587, 13'd2621,
    13'd2704, 13'd2739, 13'd2824, 13'd2831, 13'd3724, 13'd3787, 13'd3794,
    13'd3844, 13'd3868, 13'd3984, 13'd4019, 13'd4052, 13'd5083, 13'd5341,
    13'd6707, 13'd6788, 13'd6985, 13'd7001};

  typedef struct packed {
    logic       ok;
    logic [5:0] ns;
  } trans_t;

  localparam trans_t NO_TRANS = '{ok: 1'b0, ns: 6'd0};

  typedef struct packed {
    logic [3:0]  len;
    logic [12:0] sum;
  } word_t;

  typedef struct packed {
    logic [15:0] start;
    logic [15:0] stop;
    logic [3:0]  kind;
    logic        ovf;
  } token_t;

  typedef struct packed {
    token_t [MAX_TOK-1:0] tok;
    logic [CNT_W-1:0]     count;
  } bundle_t;

  function automatic logic [6:0] column_of(input logic [7:0] b);
    logic [6:0] c;
    if (b[7]) c = 7'd96;
    else if (b == 8'd10) c = 7'd95;
    else if (b < 8'd32) c = 7'd0;
    else c = 7'(b - 8'd32);
    return c;
  endfunction

  function automatic trans_t go(input int unsigned s);
    trans_t t;
    t.ok = 1'b1;
    t.ns = 6'(s);
    return t;
  endfunction

  // Transition ROM, one row per state, column from column_of().
  function automatic trans_t rom(input logic [5:0] s, input logic [6:0] c);
    logic dig, oct, up, low, hexl;
    trans_t t;
    dig  = (c >= 7'd16) && (c <= 7'd25);
    oct  = (c >= 7'd16) && (c <= 7'd23);
    up   = (c >= 7'd33) && (c <= 7'd58);
    low  = (c >= 7'd65) && (c <= 7'd90);
    hexl = (c >= 7'd65) && (c <= 7'd70);
    t = NO_TRANS;
    unique case (s)
      6'd0: begin
        unique case (c) inside
          7'd1, 7'd5, 7'd10, 7'd15, 7'd29, 7'd62: t = go(12);
          7'd2: t = go(10);
          7'd3: t = go(33);
          7'd4, 7'd63: t = go(1);
          7'd6: t = go(15);
          7'd7: t = go(23);
          7'd8, 7'd9, 7'd12, 7'd26, 7'd27, 7'd31, 7'd59, 7'd61, 7'd91, 7'd93: t = go(9);
          7'd11: t = go(13);
          7'd13: t = go(14);
          7'd14: t = go(4);
          [7'd16:7'd25]: t = go(3);
          7'd28: t = go(17);
          7'd30: t = go(18);
          [7'd33:7'd58]: t = go(1);
          7'd60: t = go(35);
          [7'd65:7'd90]: t = go(2);
          7'd92: t = go(16);
          7'd94: t = go(19);
          default: t = NO_TRANS;
        endcase
      end
      6'd1: begin
        if (c == 7'd4 || dig || up || c == 7'd63 || low) t = go(1);
        else if (c == 7'd91 || c == 7'd93) t = go(8);
      end
      6'd2: begin
        if (c == 7'd4 || dig || up || c == 7'd63) t = go(1);
        else if (low) t = go(2);
      end
      6'd3: begin
        if (c == 7'd14) t = go(5);
        else if (dig) t = go(3);
        else if (c == 7'd37 || c == 7'd69) t = go(6);
      end
      6'd4: if (dig) t = go(5);
      6'd5: begin
        if (dig) t = go(5);
        else if (c == 7'd56 || c == 7'd69) t = go(6);
      end
      6'd6: begin
        if (c == 7'd11 || c == 7'd13) t = go(7);
        else if (dig) t = go(8);
      end
      6'd7, 6'd8: if (dig) t = go(8);
      6'd10: begin
        if (c == 7'd2) t = go(11);
        else if (c < 7'd95) t = go(10);
      end
      6'd12: if (c == 7'd29) t = go(22);
      6'd13: if (c == 7'd11 || c == 7'd29) t = go(22);
      6'd14: if (c == 7'd13 || c == 7'd29 || c == 7'd30) t = go(22);
      6'd15: if (c == 7'd6 || c == 7'd29) t = go(22);
      6'd16: if (c == 7'd92) t = go(22);
      6'd17: begin
        if (c == 7'd28) t = go(20);
        else if (c == 7'd29) t = go(22);
      end
      6'd18: begin
        if (c == 7'd30) t = go(21);
        else if (c == 7'd29) t = go(22);
      end
      6'd20, 6'd21: if (c == 7'd29) t = go(22);
      6'd23: begin
        if (c >= 7'd95) t = NO_TRANS;
        else if (c == 7'd18) t = go(32);
        else if (c == 7'd60) t = go(24);
        else t = go(31);
      end
      6'd24: begin
        if (oct) t = go(27);
        else if (c == 7'd88) t = go(26);
        else if (c == 7'd2 || c == 7'd7 || c == 7'd31 || c == 7'd60 || c == 7'd65 ||
                 c == 7'd66 || c == 7'd70 || c == 7'd78 || c == 7'd82 ||
                 c == 7'd84 || c == 7'd86) t = go(25);
      end
      6'd25: if (c == 7'd7) t = go(30);
      6'd26: if (dig || hexl) t = go(28);
      6'd27: if (oct) t = go(29);
      6'd28: if (dig || hexl) t = go(25);
      6'd29: if (oct) t = go(25);
      6'd31: if (c == 7'd7) t = go(32);
      6'd33: begin
        if (c == 7'd95) t = go(34);
        else if (c != 7'd96) t = go(33);
      end
      6'd35: begin
        if (c == 7'd10) t = go(37);
        else if (c == 7'd60) t = go(36);
      end
      6'd36: begin
        if (c == 7'd95) t = go(37);
        else if (c != 7'd96) t = go(36);
      end
      default: t = NO_TRANS;
    endcase
    return t;
  endfunction

  // Adds one byte to the keyword hash; the length saturates one past the limit.
  function automatic word_t word_add(input word_t w, input logic [7:0] b);
    word_t r;
    if (w.len < 4'(MAX_KW_LEN)) begin
      r.sum = 13'(w.sum + 13'(b) * 13'({w.len, 1'b1}));
      r.len = 4'(w.len + 4'd1);
    end else begin
      r.sum = w.sum;
      r.len = 4'(MAX_KW_LEN + 1);
    end
    return r;
  endfunction

  function automatic logic [3:0] kind_of(input logic [5:0] s, input word_t w);
    logic [3:0] k;
    logic hit;
    hit = 1'b0;
    for (int i = 0; i < NUM_KW; i++) begin
      if (KW_SUMS[i] == w.sum) hit = 1'b1;
    end
    unique case (s) inside
      6'd1: k = KIND_IDENT;
      6'd2: k = (hit && w.len <= 4'(MAX_KW_LEN)) ? KIND_KEYWORD : KIND_IDENT;
      6'd3, 6'd4, 6'd5, 6'd8: k = KIND_NUMBER;
      6'd9: k = KIND_PUNCT;
      6'd11: k = KIND_STRING;
      [6'd12:6'd22]: k = KIND_OPER;
      6'd30: k = KIND_ESCAPE;
      6'd32: k = KIND_CHAR;
      6'd34: k = KIND_PREPROC;
      6'd37: k = KIND_COMMENT;
      default: k = KIND_INVALID;
    endcase
    return k;
  endfunction

endpackage

// ----- hdl/tctok_front.sv -----
module tctok_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [7:0]          source_byte,
  input  logic                end_of_text,
  input  logic                queue_full,
  output logic                push,
  output tctok_pkg::bundle_t  push_data
);
  import tctok_pkg::*;

  logic [5:0]       state, state_next;
  logic [POS_W-1:0] begin_pos, begin_pos_next;
  logic [POS_W-1:0] pos, pos_next;
  logic [7:0]       prev, prev_next;
  trans_t           prev_go, prev_go_next;
  word_t            word, word_next;
  logic             ovf, ovf_next;

  logic             accept;
  logic [6:0]       col;
  trans_t           t_cur, t_prev, t_zero;
  logic [POS_W-1:0] pos_inc, pos_dec;
  logic [3:0]       k_first, k_flush;
  word_t            prev_word;
  bundle_t          bundle;
  logic [CNT_W-1:0] n;

  assign accept   = in_valid && !queue_full;
  assign in_stall = queue_full;

  always_comb begin
    col       = column_of(source_byte);
    t_cur     = rom(state, col);
    t_prev    = rom(prev_go.ns, col);
    t_zero    = rom(ST_START, col);
    pos_inc   = POS_W'(pos + 1'b1);
    pos_dec   = POS_W'(pos - 1'b1);
    ovf_next  = ovf || (pos_inc == '0);
    prev_word = word_add('0, prev);
    k_first   = kind_of(state, word);
    k_flush   = KIND_INVALID;
    state_next     = state;
    begin_pos_next = begin_pos;
    word_next      = word;
    bundle         = '0;
    n              = '0;

    if (t_cur.ok) begin
      if (state == ST_START) begin
        begin_pos_next = pos;
        word_next      = word_add('0, source_byte);
      end else begin
        word_next = word_add(word, source_byte);
      end
      state_next = t_cur.ns;
    end else if (state != ST_START) begin
      bundle.tok[0].start = 16'(begin_pos);
      bundle.tok[0].stop  = (k_first == KIND_PREPROC || k_first == KIND_COMMENT) ?
                            16'(pos_dec) : 16'(pos);
      bundle.tok[0].kind  = k_first;
      bundle.tok[0].ovf   = ovf_next;
      n = CNT_W'(1);
      // Comment and preprocessor lines give back their last byte first.
      if ((k_first == KIND_PREPROC || k_first == KIND_COMMENT) && prev_go.ok &&
          t_prev.ok) begin
        state_next     = t_prev.ns;
        begin_pos_next = pos_dec;
        word_next      = word_add(prev_word, source_byte);
      end else begin
        if ((k_first == KIND_PREPROC || k_first == KIND_COMMENT) && prev_go.ok) begin
          bundle.tok[1].start = 16'(pos_dec);
          bundle.tok[1].stop  = 16'(pos);
          bundle.tok[1].kind  = kind_of(prev_go.ns, prev_word);
          bundle.tok[1].ovf   = ovf_next;
          n = CNT_W'(2);
        end
        if (t_zero.ok) begin
          state_next     = t_zero.ns;
          begin_pos_next = pos;
          word_next      = word_add('0, source_byte);
        end else begin
          state_next = ST_START;
        end
      end
    end

    if (end_of_text && state_next != ST_START) begin
      k_flush = kind_of(state_next, word_next);
      bundle.tok[TIDX_W'(n)].start = 16'(begin_pos_next);
      bundle.tok[TIDX_W'(n)].stop  = (k_flush == KIND_PREPROC || k_flush == KIND_COMMENT) ?
                                     16'(pos) : 16'(pos_inc);
      bundle.tok[TIDX_W'(n)].kind  = k_flush;
      bundle.tok[TIDX_W'(n)].ovf   = ovf_next;
      n = CNT_W'(n + 1'b1);
    end
    bundle.count = n;

    pos_next     = pos_inc;
    prev_next    = source_byte;
    prev_go_next = t_zero;
  end

  assign push      = accept && (n != '0);
  assign push_data = bundle;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_START;
      begin_pos <= '0;
      pos       <= '0;
      prev      <= '0;
      prev_go   <= NO_TRANS;
      word      <= '0;
      ovf       <= 1'b0;
    end else if (accept) begin
      if (end_of_text) begin
        state     <= ST_START;
        begin_pos <= '0;
        pos       <= '0;
        prev      <= '0;
        prev_go   <= NO_TRANS;
        word      <= '0;
        ovf       <= 1'b0;
      end else begin
        state     <= state_next;
        begin_pos <= begin_pos_next;
        pos       <= pos_next;
        prev      <= prev_next;
        prev_go   <= prev_go_next;
        word      <= word_next;
        ovf       <= ovf_next;
      end
    end
  end

  a_eot_clears: assert property (@(posedge clk) disable iff (rst)
    (accept && end_of_text) |=> (state == ST_START && pos == '0 && !ovf))
    else $error("state not cleared after end of text");
  a_flush_empty: assert property (@(posedge clk) disable iff (rst)
    (accept && end_of_text) |-> (state_next == ST_START || push))
    else $error("pending lexeme not flushed at end of text");

endmodule

// ----- hdl/tctok_queue.sv -----
module tctok_queue (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  tctok_pkg::bundle_t  push_data,
  output logic                full,
  input  logic                pop,
  output tctok_pkg::bundle_t  head,
  output logic                empty
);
  import tctok_pkg::*;

  bundle_t           slots [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr, rd_ptr;
  logic [QCNT_W-1:0] count;

  assign full  = (count == QCNT_W'(QDEPTH));
  assign empty = (count == '0);
  assign head  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) slots[wr_ptr] <= push_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= (wr_ptr == QPTR_W'(QDEPTH - 1)) ? '0 : QPTR_W'(wr_ptr + 1'b1);
      if (pop)  rd_ptr <= (rd_ptr == QPTR_W'(QDEPTH - 1)) ? '0 : QPTR_W'(rd_ptr + 1'b1);
      if (push && !pop) count <= QCNT_W'(count + 1'b1);
      else if (pop && !push) count <= QCNT_W'(count - 1'b1);
    end
  end

  a_no_underflow: assert property (@(posedge clk) disable iff (rst) pop |-> !empty)
    else $error("queue popped while empty");
  a_no_overflow: assert property (@(posedge clk) disable iff (rst) push |-> (!full || pop))
    else $error("queue pushed while full");

endmodule

// ----- hdl/tctok_back.sv -----
module tctok_back (
  input  logic                clk,
  input  logic                rst,
  input  tctok_pkg::bundle_t  head,
  input  logic                empty,
  output logic                pop,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [15:0]         token_start,
  output logic [15:0]         token_end,
  output logic [3:0]          token_kind,
  output logic                position_overflow,
  output logic                last_of_run
);
  import tctok_pkg::*;

  logic [TIDX_W-1:0] idx;
  token_t            cur;
  logic              done;

  assign cur       = head.tok[idx];
  assign out_valid = !empty;
  assign last_of_run = (CNT_W'(idx) == CNT_W'(head.count - 1'b1));
  assign done      = out_valid && !out_stall;
  assign pop       = done && last_of_run;

  assign token_start       = cur.start;
  assign token_end         = cur.stop;
  assign token_kind        = cur.kind;
  assign position_overflow = cur.ovf;

  always_ff @(posedge clk) begin
    if (rst) begin
      idx <= '0;
    end else if (done) begin
      idx <= last_of_run ? '0 : TIDX_W'(idx + 1'b1);
    end
  end

  a_idx_in_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (CNT_W'(idx) < head.count))
    else $error("token index past bundle count");

endmodule

// ----- hdl/table_driven_c_tokenizer_unit.sv -----
// C tokenizer driven by a 38-state transition table.
// The input channel (in_valid / in_stall) carries one source byte per
// transaction, with end_of_text marking the last byte of a text. The output
// channel (out_valid / out_stall) carries one token per transaction: start
// and end positions, kind, the sticky position overflow flag, and
// last_of_run on the final token caused by one byte.
// The front end scans one byte per cycle while the queue is not full, packing
// the up to three tokens that byte produces into a bundle; a two-entry queue
// holds bundles, and the back end hands tokens out one per cycle while out_stall
// is low. Each bundle is registered in the queue before its tokens reach the output.
// Throughput is one byte per cycle while bytes yield at most one token each
// and out_stall is low; a byte that yields several tokens holds the output until
// each is taken, and the input stalls only when the queue holds two bundles.
// When the receiver stalls, the presented token holds steady and the queue
// fills, after which in_stall is raised. Reset (rst, synchronous) empties
// the queue and returns the scanner to its start state at position zero.
// After a byte with end_of_text, all scan state, overflow flag included,
// returns to the same reset values for the next text.
module table_driven_c_tokenizer_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  source_byte,
  input  logic        end_of_text,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [15:0] token_start,
  output logic [15:0] token_end,
  output logic [3:0]  token_kind,
  output logic        position_overflow,
  output logic        last_of_run
);
  import tctok_pkg::*;

  logic    push, pop, full, empty;
  bundle_t push_data, head;

  // Scanner: runs the table and emits bundles of finished tokens.
  tctok_front u_front (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .source_byte (source_byte),
    .end_of_text (end_of_text),
    .queue_full  (full),
    .push        (push),
    .push_data   (push_data)
  );

  // Decoupling queue between scanner and token output.
  tctok_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .full      (full),
    .pop       (pop),
    .head      (head),
    .empty     (empty)
  );

  // Output stage: one token transaction per cycle from the head bundle while out_stall is low.
  tctok_back u_back (
    .clk               (clk),
    .rst               (rst),
    .head              (head),
    .empty             (empty),
    .pop               (pop),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .token_start       (token_start),
    .token_end         (token_end),
    .token_kind        (token_kind),
    .position_overflow (position_overflow),
    .last_of_run       (last_of_run)
  );

endmodule
